### sv/tcgr_pkg.sv
// ----------------------------------------------------------------------------
// Text console glyph renderer package
// Shared types, display constants, control codes and helper functions used by
// the front end, the job queue and the pixel back end.
// ----------------------------------------------------------------------------
package tcgr_pkg;

    // Display and font geometry.
    localparam int DISPLAY_WIDTH  = 128;
    localparam int DISPLAY_HEIGHT = 128;
    localparam int GLYPH_WIDTH    = 6;
    localparam int GLYPH_HEIGHT   = 8;
    localparam int FIRST_CODE     = 32;
    localparam int GLYPH_COUNT    = 96;

    // Glyph store: eight rows of eight bits for every glyph.
    localparam int STORE_DEPTH  = GLYPH_COUNT * 8;
    localparam int STORE_ADDR_W = $clog2(STORE_DEPTH);
    typedef logic [STORE_ADDR_W-1:0] t_store_addr;

    // Column counter holds 0 .. GLYPH_WIDTH-1, and GLYPH_WIDTH is at most eight.
    localparam int COL_W = 3;

    // Configuration register indexes.
    localparam logic CFG_UPWARD_SCAN = 1'b0;
    localparam logic CFG_LINE_PITCH  = 1'b1;

    // Reset values.
    localparam logic [4:0]  LINE_PITCH_RESET = 5'd8;
    localparam logic [15:0] FG_RESET         = 16'hffff;
    localparam logic [15:0] BG_RESET         = 16'h0000;
    localparam logic [15:0] GREY_COLOUR      = 16'h8410;

    // Control codes.
    localparam logic [7:0] CODE_HALF_SPACE  = 8'd3;
    localparam logic [7:0] CODE_SHORT_BACK  = 8'd4;
    localparam logic [7:0] CODE_SWAP        = 8'd7;
    localparam logic [7:0] CODE_BACKSPACE   = 8'd8;
    localparam logic [7:0] CODE_NEWLINE     = 8'd10;
    localparam logic [7:0] CODE_CLEAR       = 8'd12;
    localparam logic [7:0] CODE_RETURN      = 8'd13;
    localparam logic [7:0] CODE_GREY        = 8'd14;
    localparam logic [7:0] CODE_XTAB_FIRST  = 8'h80;
    localparam logic [7:0] CODE_XTAB_LAST   = 8'h93;
    localparam logic [7:0] CODE_YTAB_FIRST  = 8'ha0;
    localparam logic [7:0] CODE_YTAB_LAST   = 8'haf;
    localparam logic [7:0] CODE_COLOUR_FIRST = 8'hc0;
    localparam logic [7:0] SHORT_BACKSTEP   = 8'd3;

    // Display controller command bytes.
    localparam logic [7:0] CMD_COLUMN_WINDOW = 8'h75;
    localparam logic [7:0] CMD_ROW_WINDOW    = 8'h15;
    localparam logic [7:0] CMD_WRITE_RAM     = 8'h5c;
    localparam logic [7:0] ROW_MIRROR_MASK   = 8'h7f;

    // Kinds of output word.
    localparam logic [1:0] KIND_COMMAND = 2'd0;
    localparam logic [1:0] KIND_PARAM   = 2'd1;
    localparam logic [1:0] KIND_PIXEL   = 2'd2;
    localparam logic [1:0] KIND_CLEAR   = 2'd3;

    // Operations on the input channel.
    localparam logic OP_CHAR      = 1'b0;
    localparam logic OP_GLYPH_ROW = 1'b1;

    typedef struct packed {
        logic       operation;
        logic [7:0] char_code;
        logic [6:0] glyph_index;
        logic [2:0] glyph_row;
        logic [7:0] glyph_bits;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  word_kind;
        logic [15:0] word_value;
        logic        last_word;
    } t_out_item;

    typedef enum logic [1:0] {
        JOB_GLYPH_WRITE,
        JOB_CLEAR,
        JOB_PRINT
    } t_job_kind;

    // One unit of work for the back end, with a snapshot of the console state.
    typedef struct packed {
        t_job_kind   kind;
        logic [6:0]  glyph_index;
        logic [2:0]  glyph_row;
        logic [7:0]  glyph_bits;
        logic [7:0]  cursor_x;
        logic [7:0]  cursor_y;
        logic [15:0] fg;
        logic [15:0] bg;
        logic        upward_scan;
    } t_job;

    // Full or off on each RGB565 primary.
    function automatic logic [15:0] primary(input logic r, input logic g, input logic b);
        primary = {{5{r}}, {6{g}}, {5{b}}};
    endfunction

endpackage

### sv/text_console_glyph_renderer.sv
// ----------------------------------------------------------------------------
// Text console glyph renderer
// Renders character codes into display controller words for a 6x8 text mode.
// ----------------------------------------------------------------------------
// Input beats carry either a character code or one row of a glyph bitmap.
// Control codes move the cursor or change the colours and give no output.
// A printable code gives 55 output beats: column window, row window, write
// command and 48 RGB565 pixels; clear screen gives a single request beat.
// The last beat of each group has last_word set.
// The front end takes one input beat per cycle and updates the cursor at
// once; drawing work waits in a two-entry queue, so the input is stalled
// only while that queue is full.
// The back end emits one word per cycle while the output is not stalled. A
// printable code occupies it while it takes the job, sends seven header words
// and sends 48 pixels; the first word goes out through the queue, the job
// register and the output register. A glyph row write gives no output word.
// Output stalls hold the registered word and halt the header and pixel sequence in place.
// Reset (synchronous, active low) homes the cursor, restores white on
// black and empties the queue; the glyph store must be loaded before use.
// The user must write configuration only while the block is idle; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module text_console_glyph_renderer (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  tcgr_pkg::t_in_item  i_item,
    output logic                o_valid,
    input  logic                i_stall,
    output tcgr_pkg::t_out_item o_item,
    input  logic                i_cfg_we,
    input  logic                i_cfg_index,
    input  logic [4:0]          i_cfg_data
);

    logic           push;
    logic           pop;
    logic           queue_full;
    logic           queue_valid;
    tcgr_pkg::t_job front_job;
    tcgr_pkg::t_job queue_job;

    // Decode and console state.
    tcgr_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_item       (i_item),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_push       (push),
        .o_job        (front_job),
        .i_queue_full (queue_full)
    );

    // Decoupling queue.
    tcgr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .o_full  (queue_full),
        .i_pop   (pop),
        .o_valid (queue_valid),
        .o_job   (queue_job)
    );

    // Word sequencer and glyph store.
    tcgr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (queue_valid),
        .i_job       (queue_job),
        .o_pop       (pop),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_item      (o_item)
    );

endmodule

### sv/tcgr_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered read data output.
// ----------------------------------------------------------------------------
module tcgr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 768
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read; the read data holds until the next read.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### sv/tcgr_front.sv
// ----------------------------------------------------------------------------
// Glyph renderer front end
// Accepts input beats, keeps the cursor, colours and configuration, handles
// control codes at once and hands drawing and glyph store work to the queue.
// ----------------------------------------------------------------------------
module tcgr_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  tcgr_pkg::t_in_item i_item,
    input  logic              i_cfg_we,
    input  logic              i_cfg_index,
    input  logic [4:0]        i_cfg_data,
    output logic              o_push,
    output tcgr_pkg::t_job    o_job,
    input  logic              i_queue_full
);

    logic        r_upward_scan, n_upward_scan;
    logic [4:0]  r_line_pitch, n_line_pitch;
    logic [7:0]  r_cursor_x, n_cursor_x;
    logic [7:0]  r_cursor_y, n_cursor_y;
    logic [15:0] r_fg, n_fg;
    logic [15:0] r_bg, n_bg;

    logic        accept;
    logic [7:0]  code;
    logic [8:0]  newline_sum;
    logic [7:0]  newline_y;
    logic [8:0]  advance_x;

    assign o_stall = i_queue_full;
    assign accept  = i_valid && !i_queue_full;
    assign code    = i_item.char_code;

    // Newline target and the cursor after a printed glyph.
    assign newline_sum = {1'b0, r_cursor_y} + {4'b0, r_line_pitch};
    assign newline_y   = (newline_sum >= 9'(tcgr_pkg::DISPLAY_HEIGHT)) ? 8'd0
                                                                        : newline_sum[7:0];
    assign advance_x   = {1'b0, r_cursor_x} + 9'(tcgr_pkg::GLYPH_WIDTH);

    // Decode the accepted beat into state updates and an optional job.
    always_comb begin
        n_upward_scan = r_upward_scan;
        n_line_pitch  = r_line_pitch;
        n_cursor_x    = r_cursor_x;
        n_cursor_y    = r_cursor_y;
        n_fg          = r_fg;
        n_bg          = r_bg;
        o_push        = 1'b0;

        o_job.kind        = tcgr_pkg::JOB_PRINT;
        o_job.glyph_index = 7'(code - 8'(tcgr_pkg::FIRST_CODE));
        o_job.glyph_row   = i_item.glyph_row;
        o_job.glyph_bits  = i_item.glyph_bits;
        o_job.cursor_x    = r_cursor_x;
        o_job.cursor_y    = r_cursor_y;
        o_job.fg          = r_fg;
        o_job.bg          = r_bg;
        o_job.upward_scan = r_upward_scan;

        if (i_cfg_we) begin
            case (i_cfg_index)
                tcgr_pkg::CFG_UPWARD_SCAN: n_upward_scan = i_cfg_data[0];
                tcgr_pkg::CFG_LINE_PITCH:  n_line_pitch  = i_cfg_data;
                default: ;
            endcase
        end

        if (accept) begin
            if (i_item.operation == tcgr_pkg::OP_GLYPH_ROW) begin
                // Rows for glyphs beyond the font are dropped.
                o_job.kind        = tcgr_pkg::JOB_GLYPH_WRITE;
                o_job.glyph_index = i_item.glyph_index;
                o_push = (i_item.glyph_index < 7'(tcgr_pkg::GLYPH_COUNT));
            end else if (code == tcgr_pkg::CODE_HALF_SPACE) begin
                n_cursor_x = r_cursor_x + 8'(tcgr_pkg::GLYPH_WIDTH / 2);
            end else if (code == tcgr_pkg::CODE_SHORT_BACK) begin
                n_cursor_x = (r_cursor_x >= tcgr_pkg::SHORT_BACKSTEP)
                           ? r_cursor_x - tcgr_pkg::SHORT_BACKSTEP : 8'd0;
            end else if (code == tcgr_pkg::CODE_SWAP) begin
                n_fg = r_bg;
                n_bg = r_fg;
            end else if (code == tcgr_pkg::CODE_BACKSPACE) begin
                if (r_cursor_x >= 8'(tcgr_pkg::GLYPH_WIDTH)) begin
                    n_cursor_x = r_cursor_x - 8'(tcgr_pkg::GLYPH_WIDTH);
                end
            end else if (code == tcgr_pkg::CODE_NEWLINE) begin
                n_cursor_x = 8'd0;
                n_cursor_y = newline_y;
            end else if (code == tcgr_pkg::CODE_CLEAR) begin
                o_job.kind = tcgr_pkg::JOB_CLEAR;
                o_push     = 1'b1;
                n_cursor_x = 8'd0;
                n_cursor_y = 8'd0;
            end else if (code == tcgr_pkg::CODE_RETURN) begin
                n_cursor_x = 8'd0;
            end else if (code == tcgr_pkg::CODE_GREY) begin
                n_fg = tcgr_pkg::GREY_COLOUR;
            end else if (code >= tcgr_pkg::CODE_XTAB_FIRST &&
                         code <= tcgr_pkg::CODE_XTAB_LAST) begin
                n_cursor_x = 8'({3'b0, code[4:0]} * 8'(tcgr_pkg::GLYPH_WIDTH));
            end else if (code >= tcgr_pkg::CODE_YTAB_FIRST &&
                         code <= tcgr_pkg::CODE_YTAB_LAST) begin
                n_cursor_y = 8'({4'b0, code[3:0]} * {3'b0, r_line_pitch});
            end else if (code >= tcgr_pkg::CODE_COLOUR_FIRST) begin
                n_fg = tcgr_pkg::primary(code[0], code[1], code[2]);
                n_bg = tcgr_pkg::primary(code[3], code[4], code[5]);
            end else if ({1'b0, code} >= 9'(tcgr_pkg::FIRST_CODE) &&
                         {1'b0, code} < 9'(tcgr_pkg::FIRST_CODE + tcgr_pkg::GLYPH_COUNT)) begin
                // Printable: draw with the current state, then advance.
                o_push = 1'b1;
                if (advance_x >= 9'(tcgr_pkg::DISPLAY_WIDTH)) begin
                    n_cursor_x = 8'd0;
                    n_cursor_y = newline_y;
                end else begin
                    n_cursor_x = advance_x[7:0];
                end
            end
        end
    end

    // Console state and configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upward_scan <= 1'b0;
            r_line_pitch  <= tcgr_pkg::LINE_PITCH_RESET;
            r_cursor_x    <= 8'd0;
            r_cursor_y    <= 8'd0;
            r_fg          <= tcgr_pkg::FG_RESET;
            r_bg          <= tcgr_pkg::BG_RESET;
        end else begin
            r_upward_scan <= n_upward_scan;
            r_line_pitch  <= n_line_pitch;
            r_cursor_x    <= n_cursor_x;
            r_cursor_y    <= n_cursor_y;
            r_fg          <= n_fg;
            r_bg          <= n_bg;
        end
    end

endmodule

### sv/tcgr_queue.sv
// ----------------------------------------------------------------------------
// Glyph renderer job queue
// A two-entry queue of jobs between the front end and the back end.
// ----------------------------------------------------------------------------
module tcgr_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  tcgr_pkg::t_job i_job,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output tcgr_pkg::t_job o_job
);

    tcgr_pkg::t_job r_mem [2];
    logic           r_wr_ptr, n_wr_ptr;
    logic           r_rd_ptr, n_rd_ptr;
    logic [1:0]     r_count, n_count;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_job   = r_mem[r_rd_ptr];

    // Pointer and fill count updates.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = !r_wr_ptr;
        end
        if (i_pop) begin
            n_rd_ptr = !r_rd_ptr;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 2'd1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

### sv/tcgr_back.sv
// ----------------------------------------------------------------------------
// Glyph renderer back end
// Takes jobs from the queue, owns the glyph store and emits display
// controller words through a registered output stage, one beat per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
module tcgr_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_job_valid,
    input  tcgr_pkg::t_job      i_job,
    output logic                o_pop,
    output logic                o_valid,
    input  logic                i_stall,
    output tcgr_pkg::t_out_item o_item
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_HEAD,
        ST_PIX
    } t_state;

    localparam logic [2:0]            HEAD_LAST = 3'd6;
    localparam logic [2:0]            ROW_LAST  = 3'(tcgr_pkg::GLYPH_HEIGHT - 1);
    localparam logic [tcgr_pkg::COL_W-1:0] COL_LAST = tcgr_pkg::COL_W'(tcgr_pkg::GLYPH_WIDTH - 1);

    t_state                    r_state, n_state;
    tcgr_pkg::t_job            r_job, n_job;
    logic [2:0]                r_step, n_step;
    logic [2:0]                r_row, n_row;
    logic [tcgr_pkg::COL_W-1:0] r_col, n_col;
    logic [7:0]                r_bits, n_bits;
    logic                      r_out_valid, n_out_valid;
    tcgr_pkg::t_out_item       r_out, n_out;

    logic                  can_emit;
    logic                  ram_we;
    logic                  ram_re;
    tcgr_pkg::t_store_addr ram_waddr;
    tcgr_pkg::t_store_addr ram_raddr;
    logic [7:0]            ram_rdata;
    logic [7:0]            row_top;
    logic [7:0]            row_bottom;

    tcgr_ram #(
        .WIDTH (8),
        .DEPTH (tcgr_pkg::STORE_DEPTH)
    ) u_glyph_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (i_job.glyph_bits),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign can_emit  = !r_out_valid || !i_stall;
    assign ram_waddr = tcgr_pkg::t_store_addr'({i_job.glyph_index, i_job.glyph_row});

    // Row window bounds; the header mirrors them for upward scanning.
    assign row_top    = r_job.cursor_y;
    assign row_bottom = r_job.cursor_y + 8'(tcgr_pkg::GLYPH_HEIGHT - 1);

    // Sequencer: glyph store writes, clear beats, header words and pixel rows.
    always_comb begin
        n_state     = r_state;
        n_job       = r_job;
        n_step      = r_step;
        n_row       = r_row;
        n_col       = r_col;
        n_bits      = r_bits;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_stall;
        o_pop       = 1'b0;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        ram_raddr   = tcgr_pkg::t_store_addr'({i_job.glyph_index,
                                               3'd0 ^ {3{i_job.upward_scan}}});

        case (r_state)
            ST_IDLE: begin
                if (i_job_valid) begin
                    case (i_job.kind)
                        tcgr_pkg::JOB_GLYPH_WRITE: begin
                            o_pop  = 1'b1;
                            ram_we = 1'b1;
                        end
                        tcgr_pkg::JOB_CLEAR: begin
                            if (can_emit) begin
                                o_pop       = 1'b1;
                                n_out       = '{tcgr_pkg::KIND_CLEAR, i_job.bg, 1'b1};
                                n_out_valid = 1'b1;
                            end
                        end
                        tcgr_pkg::JOB_PRINT: begin
                            // Fetch the first glyph row while the header goes out.
                            o_pop   = 1'b1;
                            ram_re  = 1'b1;
                            n_job   = i_job;
                            n_step  = 3'd0;
                            n_state = ST_HEAD;
                        end
                        default: ;
                    endcase
                end
            end

            ST_HEAD: begin
                ram_raddr = tcgr_pkg::t_store_addr'({r_job.glyph_index,
                                                     3'd1 ^ {3{r_job.upward_scan}}});
                if (can_emit) begin
                    n_out_valid = 1'b1;
                    case (r_step)
                        3'd0: n_out = '{tcgr_pkg::KIND_COMMAND,
                                        {8'd0, tcgr_pkg::CMD_COLUMN_WINDOW}, 1'b0};
                        3'd1: n_out = '{tcgr_pkg::KIND_PARAM,
                                        {8'd0, r_job.cursor_x}, 1'b0};
                        3'd2: n_out = '{tcgr_pkg::KIND_PARAM,
                                        {8'd0, r_job.cursor_x +
                                               8'(tcgr_pkg::GLYPH_WIDTH - 1)}, 1'b0};
                        3'd3: n_out = '{tcgr_pkg::KIND_COMMAND,
                                        {8'd0, tcgr_pkg::CMD_ROW_WINDOW}, 1'b0};
                        3'd4: n_out = '{tcgr_pkg::KIND_PARAM, {8'd0, r_job.upward_scan
                                        ? row_bottom ^ tcgr_pkg::ROW_MIRROR_MASK
                                        : row_top}, 1'b0};
                        3'd5: n_out = '{tcgr_pkg::KIND_PARAM, {8'd0, r_job.upward_scan
                                        ? row_top ^ tcgr_pkg::ROW_MIRROR_MASK
                                        : row_bottom}, 1'b0};
                        default: n_out = '{tcgr_pkg::KIND_COMMAND,
                                           {8'd0, tcgr_pkg::CMD_WRITE_RAM}, 1'b0};
                    endcase
                    if (r_step == HEAD_LAST) begin
                        // First row is ready; fetch the second behind it.
                        n_bits  = ram_rdata;
                        ram_re  = 1'b1;
                        n_row   = 3'd0;
                        n_col   = '0;
                        n_state = ST_PIX;
                    end else begin
                        n_step = r_step + 3'd1;
                    end
                end
            end

            ST_PIX: begin
                ram_raddr = tcgr_pkg::t_store_addr'({r_job.glyph_index,
                                                     (r_row + 3'd2) ^ {3{r_job.upward_scan}}});
                if (can_emit) begin
                    n_out_valid = 1'b1;
                    n_out = '{tcgr_pkg::KIND_PIXEL, r_bits[7] ? r_job.fg : r_job.bg,
                              (r_row == ROW_LAST) && (r_col == COL_LAST)};
                    if (r_col == COL_LAST) begin
                        n_col = '0;
                        if (r_row == ROW_LAST) begin
                            n_state = ST_IDLE;
                        end else begin
                            // Next row was fetched a row ago; fetch the one after.
                            n_row  = r_row + 3'd1;
                            n_bits = ram_rdata;
                            ram_re = 1'b1;
                        end
                    end else begin
                        n_col  = r_col + tcgr_pkg::COL_W'(1);
                        n_bits = {r_bits[6:0], 1'b0};
                    end
                end
            end

            default: n_state = ST_IDLE;
        endcase
    end

    // State, job snapshot and output register.
    always_ff @(posedge i_clk) begin
        r_job  <= n_job;
        r_step <= n_step;
        r_row  <= n_row;
        r_col  <= n_col;
        r_bits <= n_bits;
        r_out  <= n_out;
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_valid = r_out_valid;
    assign o_item  = r_out;

endmodule
